FILE: rtl/core/cwct_pkg.sv
// cwct_pkg: shared constants and types for the complex wavelet threshold block.
// No dependencies.
`default_nettype none
package cwct_pkg;
	localparam int ROT_K      = 2965821;
	localparam int ROT_BITS   = 22;
	localparam int SCALE_BITS = 16;
	localparam int THR_WIDTH  = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 1'b0,
		REG_SOFT_MODE = 1'b1
	} reg_idx_t;
endpackage
`default_nettype wire

FILE: rtl/core/cwct_quad_if.sv
// cwct_quad_if: valid/ready channel carrying one quad of coefficients.
// Depends on nothing.
`default_nettype none
interface cwct_quad_if #(
	parameter int COEF_WIDTH = 24
);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] tree00;
	logic signed [COEF_WIDTH-1:0] tree01;
	logic signed [COEF_WIDTH-1:0] tree10;
	logic signed [COEF_WIDTH-1:0] tree11;

	modport source (output valid, tree00, tree01, tree10, tree11, input ready);
	modport sink   (input valid, tree00, tree01, tree10, tree11, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/complex_wavelet_coef_threshold.sv
// complex_wavelet_coef_threshold: top level of the quad magnitude threshold.
// Depends on cwct_pkg and cwct_quad_if.
//
// One quad enters per cycle unless stalled. Three input stages, one square root
// stage per magnitude bit (COEF_WIDTH + 3), 17 divider stages and three output
// stages; back pressure stalls all stages together. Inputs carry one signed
// coefficient per field; the result holds the rounded, saturated back rotation,
// or the input quad in bypass. Threshold and soft_mode may change only while idle.
`default_nettype none
module complex_wavelet_coef_threshold #(
	parameter int COEF_WIDTH = 24,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [cwct_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [cwct_pkg::CFG_DATA_W-1:0] cfg_data,
	cwct_quad_if.sink                            coef,
	cwct_quad_if.source                          result
);
	localparam int CW  = COEF_WIDTH;
	localparam int RW  = CW + 2;           // rotated values
	localparam int SQW = 2 * RW + 1;       // sum of squares
	localparam int MW  = RW + 1;           // magnitude
	localparam int NB  = MW;               // sqrt steps
	localparam int TW  = cwct_pkg::THR_WIDTH;
	localparam int DW  = MW + 1;           // denominator
	localparam int QB  = cwct_pkg::SCALE_BITS + 1; // quotient bits (s <= 2^16)
	localparam int NUMW = MW + cwct_pkg::SCALE_BITS + 1;
	localparam int KW  = 23;
	localparam int DEPTH = 3 + NB + QB + 3;

	// config registers
	logic [TW-1:0] thr_q;
	logic          soft_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			soft_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cwct_pkg::reg_idx_t'(cfg_idx))
				cwct_pkg::REG_THRESHOLD: thr_q  <= cfg_data[TW-1:0];
				cwct_pkg::REG_SOFT_MODE: soft_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic bypass;
	assign bypass = ({7'd0, thr_q} * 27'd100) <= (27'd1 << FRAC_BITS);

	// global stall: advance when output slot free or being taken
	logic adv;
	logic [DEPTH-1:0] vld_q;
	assign adv = !vld_q[DEPTH-1] || result.ready;
	assign coef.ready = adv;
	assign result.valid = vld_q[DEPTH-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-2:0], coef.valid};
	end

	// round x*K >> 22, ties away
	function automatic logic signed [RW:0] rot_round(input logic signed [RW+KW:0] p);
		logic [RW+KW:0] m;
		logic [RW+KW:0] r;
		begin
			m = p[RW+KW] ? -p : p;
			r = (m + (1 << (cwct_pkg::ROT_BITS - 1))) >> cwct_pkg::ROT_BITS;
			rot_round = p[RW+KW] ? -$signed(r[RW:0]) : $signed(r[RW:0]);
		end
	endfunction

	// stage 1: sums and differences
	logic signed [CW:0] s_ad_s1, d_ad_s1, s_bc_s1, d_bc_s1;
	logic signed [CW-1:0] a_s1, b_s1, c_s1, d_s1;
	always_ff @(posedge clk) if (adv) begin
		a_s1 <= coef.tree00; b_s1 <= coef.tree01; c_s1 <= coef.tree10; d_s1 <= coef.tree11;
		s_ad_s1 <= $signed({coef.tree00[CW-1], coef.tree00}) + coef.tree11;
		d_ad_s1 <= $signed({coef.tree00[CW-1], coef.tree00}) - coef.tree11;
		s_bc_s1 <= $signed({coef.tree01[CW-1], coef.tree01}) + coef.tree10;
		d_bc_s1 <= $signed({coef.tree01[CW-1], coef.tree01}) - coef.tree10;
	end

	// stage 2: forward rotation
	logic signed [RW-1:0] v00_s2, v11_s2, v01_s2, v10_s2;
	logic signed [CW-1:0] a_s2, b_s2, c_s2, d_s2;
	function automatic logic signed [RW-1:0] rot1(input logic signed [CW:0] x);
		logic signed [RW:0] t;
		begin
			t = rot_round((RW+KW+1)'(x) * $signed({1'b0, KW'(cwct_pkg::ROT_K)}));
			rot1 = t[RW-1:0];
		end
	endfunction
	always_ff @(posedge clk) if (adv) begin
		a_s2 <= a_s1; b_s2 <= b_s1; c_s2 <= c_s1; d_s2 <= d_s1;
		v00_s2 <= rot1(s_ad_s1); v11_s2 <= rot1(d_ad_s1);
		v01_s2 <= rot1(s_bc_s1); v10_s2 <= rot1(d_bc_s1);
	end

	// stage 3: sum of squares per pair
	logic [SQW-1:0] sq0_s3, sq1_s3;
	logic signed [RW-1:0] v00_s3, v11_s3, v01_s3, v10_s3;
	logic signed [CW-1:0] a_s3, b_s3, c_s3, d_s3;
	always_ff @(posedge clk) if (adv) begin
		a_s3 <= a_s2; b_s3 <= b_s2; c_s3 <= c_s2; d_s3 <= d_s2;
		v00_s3 <= v00_s2; v11_s3 <= v11_s2; v01_s3 <= v01_s2; v10_s3 <= v10_s2;
		sq0_s3 <= SQW'(v00_s2 * v00_s2) + SQW'(v10_s2 * v10_s2);
		sq1_s3 <= SQW'(v01_s2 * v01_s2) + SQW'(v11_s2 * v11_s2);
	end

	// per-stage payload carried through sqrt and divider
	typedef struct packed {
		logic signed [CW-1:0] a, b, c, d;
		logic signed [RW-1:0] v00, v11, v01, v10;
		logic [SQW-1:0] rem0, rem1;
		logic [MW-1:0]  r0, r1;
	} sq_t;

	sq_t sq_s [NB+1];
	assign sq_s[0] = '{a: a_s3, b: b_s3, c: c_s3, d: d_s3, v00: v00_s3, v11: v11_s3,
		v01: v01_s3, v10: v10_s3, rem0: sq0_s3, rem1: sq1_s3, r0: '0, r1: '0};

	// restoring square root, one result bit per stage (MSB first)
	for (genvar g = 0; g < NB; g++) begin : g_sqrt
		localparam int B = NB - 1 - g;
		sq_t nx;
		logic [SQW+1:0] t0, t1;
		always_comb begin
			nx = sq_s[g];
			t0 = ((SQW+2)'(sq_s[g].r0) << (B + 1)) + ((SQW+2)'(1) << (2 * B));
			t1 = ((SQW+2)'(sq_s[g].r1) << (B + 1)) + ((SQW+2)'(1) << (2 * B));
			if (t0 <= (SQW+2)'(sq_s[g].rem0)) begin
				nx.rem0 = sq_s[g].rem0 - SQW'(t0);
				nx.r0   = sq_s[g].r0 | (MW'(1) << B);
			end
			if (t1 <= (SQW+2)'(sq_s[g].rem1)) begin
				nx.rem1 = sq_s[g].rem1 - SQW'(t1);
				nx.r1   = sq_s[g].r1 | (MW'(1) << B);
			end
		end
		sq_t st_s1;
		always_ff @(posedge clk) if (adv) st_s1 <= nx;
		assign sq_s[g+1] = st_s1;
	end

	// divider: s = floor((mag<<16 + den/2) / den), one quotient bit per stage
	typedef struct packed {
		logic signed [CW-1:0] a, b, c, d;
		logic signed [RW-1:0] v00, v11, v01, v10;
		logic z0, z1;
		logic [DW-1:0]   den0, den1;
		logic [NUMW-1:0] n0, n1;
		logic [DW:0]     p0, p1;
		logic [QB-1:0]   q0, q1;
	} dv_t;

	dv_t dv_s [QB+1];
	logic [DW-1:0] den0_in, den1_in;
	assign den0_in = DW'(sq_s[NB].r0) + DW'(thr_q);
	assign den1_in = DW'(sq_s[NB].r1) + DW'(thr_q);
	assign dv_s[0] = '{a: sq_s[NB].a, b: sq_s[NB].b, c: sq_s[NB].c, d: sq_s[NB].d,
		v00: sq_s[NB].v00, v11: sq_s[NB].v11, v01: sq_s[NB].v01, v10: sq_s[NB].v10,
		z0: (sq_s[NB].r0 < MW'(thr_q)), z1: (sq_s[NB].r1 < MW'(thr_q)),
		den0: den0_in, den1: den1_in,
		n0: (NUMW'(sq_s[NB].r0) << cwct_pkg::SCALE_BITS) + NUMW'(den0_in >> 1),
		n1: (NUMW'(sq_s[NB].r1) << cwct_pkg::SCALE_BITS) + NUMW'(den1_in >> 1),
		p0: '0, p1: '0, q0: '0, q1: '0};

	for (genvar g = 0; g < QB; g++) begin : g_div
		localparam int B = QB - 1 - g;
		dv_t nx;
		logic [DW+QB:0] w0, w1;
		always_comb begin
			nx = dv_s[g];
			// partial remainder plus next numerator bits
			w0 = ((DW+QB+1)'(dv_s[g].p0) << 1) | (DW+QB+1)'(dv_s[g].n0[B]);
			w1 = ((DW+QB+1)'(dv_s[g].p1) << 1) | (DW+QB+1)'(dv_s[g].n1[B]);
			if (g == 0) begin
				w0 = (DW+QB+1)'(dv_s[g].n0 >> B);
				w1 = (DW+QB+1)'(dv_s[g].n1 >> B);
			end
			if (w0 >= (DW+QB+1)'(dv_s[g].den0)) begin
				w0 = w0 - (DW+QB+1)'(dv_s[g].den0);
				nx.q0 = dv_s[g].q0 | (QB'(1) << B);
			end
			if (w1 >= (DW+QB+1)'(dv_s[g].den1)) begin
				w1 = w1 - (DW+QB+1)'(dv_s[g].den1);
				nx.q1 = dv_s[g].q1 | (QB'(1) << B);
			end
			nx.p0 = w0[DW:0];
			nx.p1 = w1[DW:0];
		end
		dv_t st_s1;
		always_ff @(posedge clk) if (adv) st_s1 <= nx;
		assign dv_s[g+1] = st_s1;
	end

	// shrink stage: scale components (soft), pass them (hard), zero below threshold
	function automatic logic signed [RW-1:0] scl(input logic signed [RW-1:0] v,
			input logic [QB-1:0] s, input logic z, input logic soft_en);
		logic signed [RW+QB:0] p;
		logic [RW+QB:0] m, r;
		begin
			p = (RW+QB+1)'(v) * $signed({1'b0, s});
			m = p[RW+QB] ? -p : p;
			r = (m + (1 << (cwct_pkg::SCALE_BITS - 1))) >> cwct_pkg::SCALE_BITS;
			if (z) scl = '0;
			else if (!soft_en) scl = v;
			else scl = p[RW+QB] ? -$signed(r[RW-1:0]) : $signed(r[RW-1:0]);
		end
	endfunction

	dv_t dl;
	assign dl = dv_s[QB];
	logic signed [RW-1:0] w00_s4, w11_s4, w01_s4, w10_s4;
	logic signed [CW-1:0] a_s4, b_s4, c_s4, d_s4;
	always_ff @(posedge clk) if (adv) begin
		a_s4 <= dl.a; b_s4 <= dl.b; c_s4 <= dl.c; d_s4 <= dl.d;
		w00_s4 <= scl(dl.v00, dl.q0, dl.z0, soft_q);
		w10_s4 <= scl(dl.v10, dl.q0, dl.z0, soft_q);
		w01_s4 <= scl(dl.v01, dl.q1, dl.z1, soft_q);
		w11_s4 <= scl(dl.v11, dl.q1, dl.z1, soft_q);
	end

	// back rotation sums and differences
	logic signed [RW:0] e0_s5, e3_s5, e1_s5, e2_s5;
	logic signed [CW-1:0] a_s5, b_s5, c_s5, d_s5;
	always_ff @(posedge clk) if (adv) begin
		a_s5 <= a_s4; b_s5 <= b_s4; c_s5 <= c_s4; d_s5 <= d_s4;
		e0_s5 <= (RW+1)'(w00_s4) + w11_s4;
		e3_s5 <= (RW+1)'(w00_s4) - w11_s4;
		e1_s5 <= (RW+1)'(w01_s4) + w10_s4;
		e2_s5 <= (RW+1)'(w01_s4) - w10_s4;
	end

	function automatic logic signed [CW-1:0] rot_sat(input logic signed [RW:0] x);
		logic signed [RW:0] t;
		logic signed [RW:0] mx, mn;
		begin
			t = rot_round((RW+KW+1)'(x) * $signed({1'b0, KW'(cwct_pkg::ROT_K)}));
			mx = (RW+1)'((64'sd1 <<< (CW - 1)) - 1);
			mn = -mx - 1;
			if (t > mx) rot_sat = mx[CW-1:0];
			else if (t < mn) rot_sat = mn[CW-1:0];
			else rot_sat = t[CW-1:0];
		end
	endfunction

	// output register
	always_ff @(posedge clk) if (adv) begin
		result.tree00 <= bypass ? a_s5 : rot_sat(e0_s5);
		result.tree11 <= bypass ? d_s5 : rot_sat(e3_s5);
		result.tree01 <= bypass ? b_s5 : rot_sat(e1_s5);
		result.tree10 <= bypass ? c_s5 : rot_sat(e2_s5);
	end

	// a stalled result must hold
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.tree00))
		else $error("result changed under stall");
	// input ready exactly when the output slot frees
	assert property (@(posedge clk) disable iff (!arst_n)
		coef.ready == (!result.valid || result.ready))
		else $error("ready mismatch");
	// valid bits hold while the pipeline is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("valid moved while stalled");
endmodule
`default_nettype wire
